FILE: src/int_to_decimal_ascii_assert.svh
// Assertion macros shared by the int_to_decimal_ascii RTL.
// No dependencies; clock and reset are the port names clock and reset.
`ifndef INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_ASSERT_SVH

// checked only outside reset
`define I2DA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define I2DA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: src/i2da_pkg.sv
// Types and constants for the integer to decimal ASCII converter.
// No dependencies.
package i2da_pkg;

   localparam int VALUE_BITS = 32;
   localparam int PAD_BITS   = 5;
   // decimal digits needed for the magnitude 2^(VALUE_BITS-1)
   localparam int NDIG       = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [PAD_BITS-1:0]          pad_width;
   } req_word_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SCAN,
      ST_SIGN,
      ST_EMIT
   } state_type;

endpackage

FILE: src/int_to_decimal_ascii.sv
// Signed integer to zero-padded decimal ASCII, one character per output word.
// Depends on i2da_pkg and int_to_decimal_ascii_assert.svh.
// Per word: accept, one shift-add-3 step per value bit (VALUE_BITS, 32), a scan that drops
// leading zero digits, then one character per cycle while the output is not stalled: sign if
// negative, digits zero-padded so that sign and digits fill the width, NUL with last.
// Next word is taken once the NUL is loaded. Sync reset: idle, output empty.
`include "int_to_decimal_ascii_assert.svh"

module int_to_decimal_ascii
   import i2da_pkg::*;
#(
   parameter int MAX_PAD = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   localparam int CNT_TOP = (NDIG > MAX_PAD) ? NDIG : MAX_PAD;
   localparam int CW      = $clog2(CNT_TOP + 1);
   localparam logic [CW-1:0]        NDIG_CNT = CW'(NDIG);
   localparam logic [PAD_BITS-1:0]  PAD_LIM  = PAD_BITS'(MAX_PAD);
   localparam logic [BIT_CNT_W-1:0] BIT_TOP  = BIT_CNT_W'(VALUE_BITS);

   state_type               state_ff, state_in;
   logic [VALUE_BITS-1:0]   mag_ff, mag_in;
   logic [NDIG*4-1:0]       bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0]    bitcnt_ff, bitcnt_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [CW-1:0]           wp_ff, wp_in;
   logic                    neg_ff, neg_in;
   rsp_word_type            rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    load;
   logic [NDIG*4-1:0]       bcd_adj;
   logic [3:0]              dig_sel;
   logic [VALUE_BITS-1:0]   v_raw;
   logic [PAD_BITS-1:0]     w_sat;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign load      = !rsp_valid_ff || rsp_ready;
   assign v_raw     = req_word.value;
   assign w_sat     = (req_word.pad_width > PAD_LIM) ? PAD_LIM : req_word.pad_width;

   // add-3 correction on every BCD digit ahead of the shift
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                       : bcd_ff[i*4 +: 4];
      end
   end

   // digit at position cnt-1; positions past the BCD register read as zero
   always_comb begin
      dig_sel = 4'd0;
      for (int i = 0; i < NDIG; i++) begin
         if (cnt_ff == CW'(i + 1)) begin
            dig_sel = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      bitcnt_in    = bitcnt_ff;
      cnt_in       = cnt_ff;
      wp_in        = wp_ff;
      neg_in       = neg_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in    = v_raw[VALUE_BITS-1];
               mag_in    = v_raw[VALUE_BITS-1] ? (~v_raw + 1'b1) : v_raw;
               bcd_in    = '0;
               bitcnt_in = BIT_TOP;
               // the sign takes one position of the width
               if (v_raw[VALUE_BITS-1] && w_sat != '0) begin
                  wp_in = CW'(w_sat - 1'b1);
               end else begin
                  wp_in = CW'(w_sat);
               end
               state_in  = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in    = {bcd_adj[NDIG*4-2:0], mag_ff[VALUE_BITS-1]};
            mag_in    = {mag_ff[VALUE_BITS-2:0], 1'b0};
            bitcnt_in = bitcnt_ff - 1'b1;
            if (bitcnt_ff == BIT_CNT_W'(1)) begin
               cnt_in   = (wp_ff > NDIG_CNT) ? wp_ff : NDIG_CNT;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // drop leading zero digits above the pad width
            if (cnt_ff > wp_ff && dig_sel == 4'd0) begin
               cnt_in = cnt_ff - 1'b1;
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (load) begin
               rsp_in       = '{char_out: CHAR_MINUS, last: 1'b0};
               rsp_valid_in = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               if (cnt_ff == '0) begin
                  rsp_in   = '{char_out: CHAR_NUL, last: 1'b1};
                  state_in = ST_IDLE;
               end else begin
                  rsp_in = '{char_out: CHAR_ZERO + {4'd0, dig_sel}, last: 1'b0};
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      bcd_ff    <= bcd_in;
      bitcnt_ff <= bitcnt_in;
      cnt_ff    <= cnt_in;
      wp_ff     <= wp_in;
      neg_ff    <= neg_in;
      rsp_ff    <= rsp_in;
   end

   `I2DA_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff), "not idle after reset")
   `I2DA_ASSERT(a_accept_conv, (req_valid && req_ready) |=> (state_ff == ST_CONV && bitcnt_ff == BIT_TOP), "accept did not start conversion")
   `I2DA_ASSERT(a_scan_floor, (state_ff == ST_SCAN) |-> (cnt_ff >= wp_ff), "scan went below pad width")
   `I2DA_ASSERT(a_sign_neg, (state_ff == ST_SIGN) |-> neg_ff, "sign state on positive value")
   `I2DA_ASSERT(a_nul_last, (state_ff == ST_EMIT && cnt_ff == '0 && load) |=> (rsp_valid_ff && rsp_ff.last && state_ff == ST_IDLE), "terminator not loaded")

endmodule
